/* src/gfsl_pkg.sv */
// Package for the gray frame spot locator: sizes, register indexes, command
// and result codes, the frame RAM request type and the gray weighting function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gfsl_pkg;

  // frame geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int PIX_W      = 8;

  // register field widths
  localparam int FW_W  = 11;
  localparam int FH_W  = 10;
  localparam int HL_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_HALF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE   = 3'd3;

  // register reset values
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 10'd480;
  localparam logic [HL_W-1:0] CROSS_HALF_RST   = 6'd10;

  // command and result kind codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_READOUT = 1'b1;
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_SPOT   = 1'b1;

  // gray weights in Q0.10
  localparam int WGT_B = 102;
  localparam int WGT_G = 614;
  localparam int WGT_R = 307;
  localparam int GRAY_SHIFT = 10;
  localparam int GSUM_W = 18;

  localparam logic [PIX_W-1:0] FULL_RED = 8'd255;

  // one access to the single-port frame RAM
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } gfsl_ram_req_t;

  // weighted sum of the three components, truncated to eight bits
  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] r);
    logic [GSUM_W-1:0] sum;
    sum = GSUM_W'(b) * GSUM_W'(WGT_B) + GSUM_W'(g) * GSUM_W'(WGT_G)
        + GSUM_W'(r) * GSUM_W'(WGT_R);
    return sum[GRAY_SHIFT +: PIX_W];
  endfunction

endpackage
`default_nettype wire

/* src/gray_frame_spot_locator.sv */
// Top level of the gray frame spot locator: load and readout pipeline, spot
// tracker, configuration registers. Uses gfsl_pkg and gfsl_frame_ram.
//
//   channel   direction  ports                              accepted when
//   in        input      in_command, in_*_in                in_valid & in_ready
//   out       output     out_kind, out_*                    out_valid & out_ready
//   cfg       input      cfg_index, cfg_data                cfg_valid & cfg_ready
//
// One item per cycle while the output does not stall; a stall holds a full stage 1
// and the output register. An item is registered at accept, then makes its single
// RAM access (write for a load, read for a readout) as the pipe advances, which
// also loads the result register. Synchronous active-low reset clears counters,
// tracker and spot, resets the config registers; the frame RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module gray_frame_spot_locator (
  input  wire                              clk,
  input  wire                              rst_n,
  // input items
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_command,
  input  wire  [gfsl_pkg::PIX_W-1:0]       in_blue_in,
  input  wire  [gfsl_pkg::PIX_W-1:0]       in_green_in,
  input  wire  [gfsl_pkg::PIX_W-1:0]       in_red_in,
  // result items
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_kind,
  output logic [gfsl_pkg::PIX_W-1:0]       out_blue_out,
  output logic [gfsl_pkg::PIX_W-1:0]       out_green_out,
  output logic [gfsl_pkg::PIX_W-1:0]       out_red_out,
  output logic [gfsl_pkg::PIX_W-1:0]       out_alpha_out,
  output logic [gfsl_pkg::COL_W-1:0]       out_pixel_col,
  output logic [gfsl_pkg::ROW_W-1:0]       out_pixel_row,
  output logic                             out_last_of_frame,
  output logic [gfsl_pkg::COL_W-1:0]       out_spot_col_out,
  output logic [gfsl_pkg::ROW_W-1:0]       out_spot_row_out,
  output logic [gfsl_pkg::PIX_W-1:0]       out_spot_level,
  // configuration writes
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [gfsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [gfsl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gfsl_pkg::*;

  // configuration registers
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic [HL_W-1:0] cross_half_r;
  logic            alpha_mode_r;

  // position counters, tracker, latched spot
  logic [COL_W-1:0] load_col_r, read_col_r;
  logic [ROW_W-1:0] load_row_r, read_row_r;
  logic [PIX_W-1:0] best_level_r;
  logic [COL_W-1:0] best_col_r, spot_col_r;
  logic [ROW_W-1:0] best_row_r, spot_row_r;

  // stage 1: accepted item
  logic             s1_valid_r;
  logic             s1_cmd_r;
  logic [PIX_W-1:0] s1_b_r, s1_g_r, s1_r_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_end_r;

  // stage 2: output register
  logic             out_valid_r;
  logic             out_kind_r;
  logic             out_cross_r;
  logic             out_spot_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic             out_last_r;
  logic [COL_W-1:0] rep_col_r;
  logic [ROW_W-1:0] rep_row_r;
  logic [PIX_W-1:0] rep_level_r;

  logic             adv;
  logic             in_acc;
  logic [FW_W-1:0]  eff_w;
  logic [FH_W-1:0]  eff_h;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             col_wrap, row_wrap;
  logic [PIX_W-1:0] s1_gray;
  logic             brighter;
  logic [PIX_W-1:0] best_level_nxt;
  logic [COL_W-1:0] best_col_nxt;
  logic [ROW_W-1:0] best_row_nxt;
  logic             on_h, on_v, is_spot;
  logic             s1_has_result;
  logic [PIX_W-1:0] rd_data;
  gfsl_ram_req_t    ram_req;

  // pipe moves whenever the output register is free or being taken
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // effective frame size: zero counts as one, clip to the maxima
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = FW_W'(1);
    end else if (frame_width_r > FW_W'(MAX_WIDTH)) begin
      eff_w = FW_W'(MAX_WIDTH);
    end else begin
      eff_w = frame_width_r;
    end
    if (frame_height_r == '0) begin
      eff_h = FH_W'(1);
    end else if (frame_height_r > FH_W'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height_r;
    end
  end

  // position of the incoming item and its end-of-row / end-of-frame tests
  assign cur_col  = (in_command == CMD_LOAD) ? load_col_r : read_col_r;
  assign cur_row  = (in_command == CMD_LOAD) ? load_row_r : read_row_r;
  assign col_wrap = (FW_W'(cur_col) + FW_W'(1)) >= eff_w;
  assign row_wrap = (FH_W'(cur_row) + FH_W'(1)) >= eff_h;

  // counters and stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_col_r <= '0;
      load_row_r <= '0;
      read_col_r <= '0;
      read_row_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_command == CMD_LOAD) begin
          load_col_r <= col_wrap ? '0 : load_col_r + COL_W'(1);
          if (col_wrap) begin
            load_row_r <= row_wrap ? '0 : load_row_r + ROW_W'(1);
          end
        end else begin
          read_col_r <= col_wrap ? '0 : read_col_r + COL_W'(1);
          if (col_wrap) begin
            read_row_r <= row_wrap ? '0 : read_row_r + ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_command;
      s1_b_r   <= in_blue_in;
      s1_g_r   <= in_green_in;
      s1_r_r   <= in_red_in;
      s1_col_r <= cur_col;
      s1_row_r <= cur_row;
      s1_end_r <= col_wrap && row_wrap;
    end
  end

  // gray level and tracker update for a load in stage 1
  assign s1_gray  = gray_of(s1_b_r, s1_g_r, s1_r_r);
  assign brighter = s1_gray > best_level_r;
  assign best_level_nxt = brighter ? s1_gray  : best_level_r;
  assign best_col_nxt   = brighter ? s1_col_r : best_col_r;
  assign best_row_nxt   = brighter ? s1_row_r : best_row_r;

  // cross and spot tests for a readout in stage 1
  assign on_h = (s1_row_r == spot_row_r)
             && ((FW_W'(s1_col_r) + FW_W'(cross_half_r)) >= FW_W'(spot_col_r))
             && (FW_W'(s1_col_r) < (FW_W'(spot_col_r) + FW_W'(cross_half_r)));
  assign on_v = (s1_col_r == spot_col_r)
             && ((FH_W'(s1_row_r) + FH_W'(cross_half_r)) >= FH_W'(spot_row_r))
             && (FH_W'(s1_row_r) < (FH_W'(spot_row_r) + FH_W'(cross_half_r)));
  assign is_spot = (s1_col_r == spot_col_r) && (s1_row_r == spot_row_r);

  assign s1_has_result = (s1_cmd_r == CMD_READOUT) || s1_end_r;

  // one RAM access per stage 1 item
  always_comb begin
    ram_req.en    = s1_valid_r && adv;
    ram_req.we    = (s1_cmd_r == CMD_LOAD);
    ram_req.addr  = {s1_row_r, s1_col_r};
    ram_req.wdata = s1_gray;
  end

  gfsl_frame_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // tracker, spot latch and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_level_r <= '0;
      best_col_r   <= '0;
      best_row_r   <= '0;
      spot_col_r   <= '0;
      spot_row_r   <= '0;
      out_valid_r  <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && s1_has_result;
      if (s1_valid_r && (s1_cmd_r == CMD_LOAD)) begin
        if (s1_end_r) begin
          spot_col_r   <= best_col_nxt;
          spot_row_r   <= best_row_nxt;
          best_level_r <= '0;
          best_col_r   <= '0;
          best_row_r   <= '0;
        end else begin
          best_level_r <= best_level_nxt;
          best_col_r   <= best_col_nxt;
          best_row_r   <= best_row_nxt;
        end
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_kind_r  <= (s1_cmd_r == CMD_LOAD) ? KIND_SPOT : KIND_PIXEL;
      out_cross_r <= on_h || on_v;
      out_spot_r  <= is_spot;
      out_col_r   <= s1_col_r;
      out_row_r   <= s1_row_r;
      out_last_r  <= s1_end_r;
      rep_col_r   <= best_col_nxt;
      rep_row_r   <= best_row_nxt;
      rep_level_r <= best_level_nxt;
    end
  end

  // output fields; unused fields of each kind read as zero
  always_comb begin
    out_blue_out      = '0;
    out_green_out     = '0;
    out_red_out       = '0;
    out_alpha_out     = '0;
    out_pixel_col     = '0;
    out_pixel_row     = '0;
    out_last_of_frame = 1'b0;
    out_spot_col_out  = '0;
    out_spot_row_out  = '0;
    out_spot_level    = '0;
    if (out_kind_r == KIND_SPOT) begin
      out_spot_col_out = rep_col_r;
      out_spot_row_out = rep_row_r;
      out_spot_level   = rep_level_r;
    end else begin
      out_pixel_col     = out_col_r;
      out_pixel_row     = out_row_r;
      out_last_of_frame = out_last_r;
      out_alpha_out     = alpha_mode_r ? rd_data : '0;
      if (out_cross_r) begin
        out_red_out   = FULL_RED;
        out_alpha_out = '0;
      end else if (out_spot_r) begin
        out_red_out   = FULL_RED;
      end else begin
        out_blue_out  = rd_data;
        out_green_out = rd_data;
        out_red_out   = rd_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      cross_half_r   <= CROSS_HALF_RST;
      alpha_mode_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        REG_CROSS_HALF:   cross_half_r   <= cfg_data[HL_W-1:0];
        REG_ALPHA_MODE:   alpha_mode_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/gfsl_frame_ram.sv */
// Single-port frame RAM holding one gray level per pixel, row-major at full
// row stride. Registered read data. Uses gfsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gfsl_frame_ram (
  input  wire                          clk,
  input  gfsl_pkg::gfsl_ram_req_t      req,
  output logic [gfsl_pkg::PIX_W-1:0]   rd_data
);
  import gfsl_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [PIX_W-1:0] mem [DEPTH];

  // write or read one entry per enabled cycle; read data holds otherwise
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rd_data <= mem[req.addr];
      end
    end
  end

endmodule
`default_nettype wire
